@@ hw/rtl/bts_pkg.sv @@
package bts_pkg;

	// Address source for a node memory read.
	typedef enum logic [1:0] {
		SEL_ROOT  = 2'd0,
		SEL_LEFT  = 2'd1,
		SEL_RIGHT = 2'd2,
		SEL_STACK = 2'd3
	} rd_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    drop;
		logic    ins_write;
		logic    node_rd;
		rd_sel_t rd_sel;
		logic    link_wr;
		logic    tally_inc;
		logic    tally_final;
		logic    push;
		logic    pop_rd;
		logic    emit;
		logic    clear;
	} bts_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic total_zero;
		logic less;
		logic left_valid;
		logic right_valid;
		logic sp_zero;
	} bts_status_t;

	localparam int KEY_W   = 32;
	localparam int TALLY_W = 12;
	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

endpackage

@@ hw/rtl/bts_ctrl.sv @@
module bts_ctrl import bts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        last_item,
	input  bts_status_t status,
	output logic        busy,
	output bts_cmd_t    cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_WALK = 7'b0000010,
		S_SORT = 7'b0000100,
		S_PUSH = 7'b0001000,
		S_POP  = 7'b0010000,
		S_POPW = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   last_q, last_d;

	// State and last marker registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// Next state and command decode.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		last_d  = last_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					last_d = last_item;
					if (status.full) begin
						cmd.drop = 1'b1;
						state_d  = last_item ? S_SORT : S_IDLE;
					end else begin
						cmd.ins_write = 1'b1;
						if (status.total_zero) begin
							state_d = last_item ? S_SORT : S_IDLE;
						end else begin
							cmd.node_rd = 1'b1;
							cmd.rd_sel  = SEL_ROOT;
							state_d     = S_WALK;
						end
					end
				end
			end
			S_WALK: begin
				cmd.tally_inc = 1'b1;
				if (status.less ? !status.left_valid : !status.right_valid) begin
					cmd.link_wr = 1'b1;
					state_d     = last_q ? S_SORT : S_IDLE;
				end else begin
					cmd.node_rd = 1'b1;
					cmd.rd_sel  = status.less ? SEL_LEFT : SEL_RIGHT;
				end
			end
			S_SORT: begin
				cmd.tally_final = 1'b1;
				if (status.total_zero) begin
					cmd.clear = 1'b1;
					state_d   = S_IDLE;
				end else begin
					cmd.node_rd = 1'b1;
					cmd.rd_sel  = SEL_ROOT;
					state_d     = S_PUSH;
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				if (status.left_valid) begin
					cmd.node_rd = 1'b1;
					cmd.rd_sel  = SEL_LEFT;
				end else begin
					state_d = S_POP;
				end
			end
			S_POP: begin
				if (status.sp_zero) begin
					cmd.clear = 1'b1;
					state_d   = S_IDLE;
				end else begin
					cmd.pop_rd = 1'b1;
					state_d    = S_POPW;
				end
			end
			S_POPW: begin
				cmd.node_rd = 1'b1;
				cmd.rd_sel  = SEL_STACK;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (status.right_valid) begin
					cmd.node_rd = 1'b1;
					cmd.rd_sel  = SEL_RIGHT;
					state_d     = S_PUSH;
				end else begin
					state_d = S_POP;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/bts_datapath.sv @@
module bts_datapath import bts_pkg::*; #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bts_cmd_t                  cmd,
	input  logic signed [KEY_W-1:0]   value,
	output bts_status_t               status,
	output logic                      strobe,
	output logic signed [KEY_W-1:0]   sorted_value,
	output logic                      last_result,
	output logic                      overflow,
	output logic [TALLY_W-1:0]        work_count
);

	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int LNK_W = IDX_W + 1;
	localparam int SUM_W = TALLY_W + 1;

	// Node and stack memories; a link's top bit marks a present child.
	logic signed [KEY_W-1:0] key_mem   [MAX_ITEMS];
	logic [LNK_W-1:0]        left_mem  [MAX_ITEMS];
	logic [LNK_W-1:0]        right_mem [MAX_ITEMS];
	logic [IDX_W-1:0]        stack_mem [MAX_ITEMS];

	logic signed [KEY_W-1:0] rd_key_q;
	logic [LNK_W-1:0]        rd_left_q, rd_right_q;
	logic [IDX_W-1:0]        stk_rd_q;

	logic signed [KEY_W-1:0] key_q;
	logic [IDX_W-1:0]        slot_q, ptr_q, node_rd_addr, slot_idx;
	logic [CNT_W-1:0]        total_q, sp_q, sp_dec;
	logic [TALLY_W-1:0]      tally_q;
	logic                    dropped_q;
	logic [SUM_W-1:0]        addend, tally_sum;
	logic                    less, emit_last;

	logic                    strobe_q, last_result_q, overflow_q;
	logic signed [KEY_W-1:0] sorted_value_q;
	logic [TALLY_W-1:0]      work_count_q;

	assign slot_idx = total_q[IDX_W-1:0];
	assign sp_dec   = sp_q - CNT_W'(1);
	assign less     = (key_q < rd_key_q);

	// Node read address selection.
	always_comb begin
		unique case (cmd.rd_sel)
			SEL_ROOT:  node_rd_addr = '0;
			SEL_LEFT:  node_rd_addr = rd_left_q[IDX_W-1:0];
			SEL_RIGHT: node_rd_addr = rd_right_q[IDX_W-1:0];
			SEL_STACK: node_rd_addr = stk_rd_q;
		endcase
	end

	// Node memory writes: a new node, or a link to it from its parent.
	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			key_mem[slot_idx]   <= value;
			left_mem[slot_idx]  <= '0;
			right_mem[slot_idx] <= '0;
		end else if (cmd.link_wr) begin
			if (less) begin
				left_mem[ptr_q] <= {1'b1, slot_q};
			end else begin
				right_mem[ptr_q] <= {1'b1, slot_q};
			end
		end
	end

	// Registered node memory reads.
	always_ff @(posedge clk) begin
		if (cmd.node_rd) begin
			rd_key_q   <= key_mem[node_rd_addr];
			rd_left_q  <= left_mem[node_rd_addr];
			rd_right_q <= right_mem[node_rd_addr];
		end
	end

	// Walk stack memory, written on push and read on pop.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[sp_q[IDX_W-1:0]] <= ptr_q;
		end
		if (cmd.pop_rd) begin
			stk_rd_q <= stack_mem[sp_dec[IDX_W-1:0]];
		end
	end

	// Payload registers for the key being inserted and the current node.
	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			key_q  <= value;
			slot_q <= slot_idx;
		end
		if (cmd.node_rd) begin
			ptr_q <= node_rd_addr;
		end
	end

	// Tally increment for the current step.
	always_comb begin
		priority if (cmd.tally_final) begin
			addend = (SUM_W'(total_q) << 1) + SUM_W'(2);
		end else if (cmd.ins_write) begin
			addend = SUM_W'(2);
		end else if (cmd.tally_inc) begin
			addend = SUM_W'(1);
		end else begin
			addend = '0;
		end
		tally_sum = {1'b0, tally_q} + addend;
	end

	// Run state: node count, stack pointer, tally and drop flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			sp_q      <= '0;
			tally_q   <= '0;
			dropped_q <= 1'b0;
		end else if (cmd.clear) begin
			total_q   <= '0;
			sp_q      <= '0;
			tally_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.ins_write) begin
				total_q <= total_q + CNT_W'(1);
			end
			if (cmd.drop) begin
				dropped_q <= 1'b1;
			end
			if (cmd.push) begin
				sp_q <= sp_q + CNT_W'(1);
			end else if (cmd.pop_rd) begin
				sp_q <= sp_dec;
			end
			tally_q <= tally_sum[TALLY_W] ? TALLY_MAX : tally_sum[TALLY_W-1:0];
		end
	end

	assign emit_last = !rd_right_q[IDX_W] && (sp_q == '0);

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sorted_value_q <= rd_key_q;
			last_result_q  <= emit_last;
			overflow_q     <= dropped_q;
			work_count_q   <= emit_last ? tally_q : '0;
		end
	end

	assign status.full        = (total_q == CNT_W'(MAX_ITEMS));
	assign status.total_zero  = (total_q == '0);
	assign status.less        = less;
	assign status.left_valid  = rd_left_q[IDX_W];
	assign status.right_valid = rd_right_q[IDX_W];
	assign status.sp_zero     = (sp_q == '0);

	assign strobe       = strobe_q;
	assign sorted_value = sorted_value_q;
	assign last_result  = last_result_q;
	assign overflow     = overflow_q;
	assign work_count   = work_count_q;

endmodule

@@ hw/rtl/binary_tree_sort_unit.sv @@
// Tree sort: a key is dropped if the tree is full and the first key becomes the root;
// any other key walks down from the root, visiting up to MAX_ITEMS - 1 nodes.
// The walk makes one registered node memory read per node.
// After the last key an in-order walk with a stack emits the keys in ascending signed order.
// Results come with a one-cycle strobe; the receiver cannot stall them.
// Asynchronous reset empties the tree and clears tally and drop flag; no clearing pass.
module binary_tree_sort_unit import bts_pkg::*; #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [KEY_W-1:0] value,
	input  logic                    last_item,
	output logic                    strobe,
	output logic signed [KEY_W-1:0] sorted_value,
	output logic                    last_result,
	output logic                    overflow,
	output logic [TALLY_W-1:0]      work_count
);

	bts_cmd_t    cmd;
	bts_status_t status;

	// Sequencer for insertion and in-order walk.
	bts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_item (last_item),
		.status    (status),
		.busy      (busy),
		.cmd       (cmd)
	);

	// Node memories, walk stack and result registers.
	bts_datapath #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (value),
		.status       (status),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.last_result  (last_result),
		.overflow     (overflow),
		.work_count   (work_count)
	);

endmodule
